[hw/rtl/adr_pkg.sv]
// Shared types, constants and helpers for the Art-Net ArtDmx receiver.
package adr_pkg;

    // Channel store depth default
    localparam int CHANNELS_DEF = 512;

    // Packet layout
    localparam int        MIN_PACKET    = 12;
    localparam logic [9:0] DATA_START   = 10'd18;
    localparam logic [9:0] POS_OPCODE_LO = 10'd8;
    localparam logic [9:0] POS_OPCODE_HI = 10'd9;
    localparam logic [9:0] POS_VER_HI    = 10'd10;
    localparam logic [9:0] POS_VER_LO    = 10'd11;
    localparam logic [9:0] POS_UNIV_LO   = 10'd14;
    localparam logic [9:0] POS_UNIV_HI   = 10'd15;
    localparam logic [9:0] POS_LEN_HI    = 10'd16;
    localparam logic [9:0] POS_LEN_LO    = 10'd17;
    localparam logic [9:0] POS_MAX       = 10'd1023;

    // Opcodes and protocol version
    localparam logic [15:0] OP_DMX        = 16'h5000;
    localparam logic [15:0] OP_POLL       = 16'h2000;
    localparam logic [15:0] OP_POLL_REPLY = 16'h2100;
    localparam logic [15:0] PROTO_VERSION = 16'd14;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNIVERSE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_COUNT   = 8'd1;

    // End-of-packet status codes
    typedef enum logic [2:0] {
        ST_DMX_ACCEPTED  = 3'd0,
        ST_POLL_WANTED   = 3'd1,
        ST_POLL_IGNORED  = 3'd2,
        ST_TOO_SHORT     = 3'd3,
        ST_BAD_HEADER    = 3'd4,
        ST_OTHER_UNIVERSE = 3'd5,
        ST_NO_OUTPUT     = 3'd6,
        ST_UNKNOWN_OP    = 3'd7
    } adr_status_t;

    // Input word
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
    } adr_in_t;

    // Result word
    typedef struct packed {
        logic       channel_write;
        logic [8:0] channel;
        logic [7:0] level;
        logic       packet_done;
        logic [2:0] status;
        logic       any_changed;
    } adr_out_t;

    // Ident bytes "Art-Net" and a trailing zero
    function automatic logic [7:0] ident_byte(input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0:    b = 8'h41;
            3'd1:    b = 8'h72;
            3'd2:    b = 8'h74;
            3'd3:    b = 8'h2D;
            3'd4:    b = 8'h4E;
            3'd5:    b = 8'h65;
            3'd6:    b = 8'h74;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/adr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module adr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/artnet_dmx_receiver_top.sv]
// Top level of the Art-Net ArtDmx receiver: header parse, channel store, results.
//
// Usage:
//   pkt_*  : UDP payload, one byte per word (payload_byte, last_byte marks the end).
//   res_*  : result words; one is given for a byte that changes a stored channel,
//            for the last byte of a packet, or both. Other bytes give no word.
//   cfg_*  : register writes (index 0 first_universe, 1 output_count); cfg_ready
//            is always high. Write only while no packet is in flight.
// Path: a byte goes through the parse stage, then the store read/compare stage,
//   then the output register, whose word shows on res_*.
// Throughput: one byte per cycle while pkt_stall is low; the channel store is read
//   in the parse stage and written back from the compare stage, so each byte costs
//   one read and at most one write of the store.
// Reset: all packet state clears at once; the channel store is then swept to
//   zero, one entry per cycle, through all CHANNELS entries (512 by default),
//   during which pkt_stall is high. Config writes are taken during the sweep.
// Stall: with res_stall high on a valid word the output register holds it; bytes
//   with no result still pass, and pkt_stall rises once one with a result waits.
module artnet_dmx_receiver_top #(
    parameter int CHANNELS = adr_pkg::CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pkt_valid,
    output logic                            pkt_stall,
    input  adr_pkg::adr_in_t                pkt_word,
    output logic                            res_valid,
    input  logic                            res_stall,
    output adr_pkg::adr_out_t               res_word,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [adr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [adr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [9:0] CHAN_LIMIT = 10'(CHANNELS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CHANNELS - 1);

    // Configuration registers
    logic [14:0] first_universe_reg;
    logic [9:0]  output_count_reg;

    // Packet state (parse stage)
    logic [9:0]  pos_reg, pos_next;
    logic        header_ok_reg, header_ok_next;
    logic [15:0] opcode_reg, opcode_next;
    logic [15:0] version_reg, version_next;
    logic [15:0] universe_reg, universe_next;
    logic [15:0] length_reg, length_next;

    // Compare stage
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_cand_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [7:0]    s1_byte_reg;
    logic          s1_last_reg;
    logic [2:0]    s1_status_reg;
    logic          s1_fwd_reg;
    logic [7:0]    s1_fwd_data_reg;
    logic          change_seen_reg, change_seen_next;

    // Output register
    logic               res_valid_reg, res_valid_next;
    adr_pkg::adr_out_t  res_word_reg, res_word_next;

    // Store clearing sweep
    logic          clr_reg;
    logic [AW-1:0] clr_addr_reg;

    // Store ports
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;

    // Parse-stage decode
    logic          accept;
    logic [9:0]    idx;
    logic [9:0]    oc_eff;
    logic [9:0]    limit;
    logic          dmx_ok;
    logic          cand;
    logic          header_good_next;
    adr_pkg::adr_status_t status_now;

    // Compare-stage decode
    logic [7:0] old_level;
    logic       cw;
    logic       has_result;
    logic       out_free;
    logic       s1_done;

    assign cfg_ready = 1'b1;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_universe_reg <= '0;
            output_count_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == adr_pkg::CFG_FIRST_UNIVERSE)
            begin
                first_universe_reg <= cfg_data[14:0];
            end
            else if (cfg_index == adr_pkg::CFG_OUTPUT_COUNT)
            begin
                output_count_reg <= cfg_data[9:0];
            end
        end
    end

    // Handshake
    assign out_free  = !res_valid_reg || !res_stall;
    assign s1_done   = s1_valid_reg && (!has_result || out_free);
    assign pkt_stall = clr_reg || (s1_valid_reg && !s1_done);
    assign accept    = pkt_valid && !pkt_stall;

    // Channel limit and ArtDmx acceptance from current packet state
    always_comb
    begin
        oc_eff = (output_count_reg > CHAN_LIMIT) ? CHAN_LIMIT : output_count_reg;
        limit  = (length_reg < {6'd0, oc_eff}) ? length_reg[9:0] : oc_eff;
        dmx_ok = header_ok_reg && (version_reg == adr_pkg::PROTO_VERSION) &&
                 (opcode_reg == adr_pkg::OP_DMX) &&
                 (universe_reg == {1'b0, first_universe_reg}) &&
                 (output_count_reg != 10'd0);
        idx    = pos_reg - adr_pkg::DATA_START;
        cand   = (pos_reg >= adr_pkg::DATA_START) && dmx_ok && (idx < limit);
    end

    // Header field capture
    always_comb
    begin
        header_ok_next = header_ok_reg;
        opcode_next    = opcode_reg;
        version_next   = version_reg;
        universe_next  = universe_reg;
        length_next    = length_reg;
        if (pos_reg < adr_pkg::POS_OPCODE_LO)
        begin
            if (pkt_word.payload_byte != adr_pkg::ident_byte(pos_reg[2:0]))
            begin
                header_ok_next = 1'b0;
            end
        end
        else
        begin
            case (pos_reg)
                adr_pkg::POS_OPCODE_LO: opcode_next[7:0]    = pkt_word.payload_byte;
                adr_pkg::POS_OPCODE_HI: opcode_next[15:8]   = pkt_word.payload_byte;
                adr_pkg::POS_VER_HI:    version_next[15:8]  = pkt_word.payload_byte;
                adr_pkg::POS_VER_LO:    version_next[7:0]   = pkt_word.payload_byte;
                adr_pkg::POS_UNIV_LO:   universe_next[7:0]  = pkt_word.payload_byte;
                adr_pkg::POS_UNIV_HI:   universe_next[15:8] = pkt_word.payload_byte;
                adr_pkg::POS_LEN_HI:    length_next[15:8]   = pkt_word.payload_byte;
                adr_pkg::POS_LEN_LO:    length_next[7:0]    = pkt_word.payload_byte;
                default: ;
            endcase
        end
        pos_next = (pos_reg == adr_pkg::POS_MAX) ? pos_reg : pos_reg + 10'd1;
    end

    // End status as it stands after this byte; count is pos + 1
    always_comb
    begin
        header_good_next = header_ok_next && (version_next == adr_pkg::PROTO_VERSION);
        if (pos_reg < 10'(adr_pkg::MIN_PACKET - 1))
        begin
            status_now = adr_pkg::ST_TOO_SHORT;
        end
        else if (!header_good_next)
        begin
            status_now = adr_pkg::ST_BAD_HEADER;
        end
        else if (opcode_next == adr_pkg::OP_DMX)
        begin
            if (universe_next != {1'b0, first_universe_reg})
            begin
                status_now = adr_pkg::ST_OTHER_UNIVERSE;
            end
            else if (output_count_reg == 10'd0)
            begin
                status_now = adr_pkg::ST_NO_OUTPUT;
            end
            else
            begin
                status_now = adr_pkg::ST_DMX_ACCEPTED;
            end
        end
        else if (opcode_next == adr_pkg::OP_POLL)
        begin
            status_now = adr_pkg::ST_POLL_WANTED;
        end
        else if (opcode_next == adr_pkg::OP_POLL_REPLY)
        begin
            status_now = adr_pkg::ST_POLL_IGNORED;
        end
        else
        begin
            status_now = adr_pkg::ST_UNKNOWN_OP;
        end
    end

    // Parse-stage registers; a last byte returns the packet state to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            header_ok_reg <= 1'b1;
            opcode_reg    <= '0;
            version_reg   <= '0;
            universe_reg  <= '0;
            length_reg    <= '0;
        end
        else if (accept)
        begin
            if (pkt_word.last_byte)
            begin
                pos_reg       <= '0;
                header_ok_reg <= 1'b1;
                opcode_reg    <= '0;
                version_reg   <= '0;
                universe_reg  <= '0;
                length_reg    <= '0;
            end
            else
            begin
                pos_reg       <= pos_next;
                header_ok_reg <= header_ok_next;
                opcode_reg    <= opcode_next;
                version_reg   <= version_next;
                universe_reg  <= universe_next;
                length_reg    <= length_next;
            end
        end
    end

    // Store access: read in parse stage, write back from compare stage
    assign mem_rd_en   = accept;
    assign mem_rd_addr = idx[AW-1:0];
    assign mem_wr_en   = clr_reg || (s1_done && cw);
    assign mem_wr_addr = clr_reg ? clr_addr_reg : s1_addr_reg;
    assign mem_wr_data = clr_reg ? 8'd0 : s1_byte_reg;

    adr_ram #(
        .WIDTH (8),
        .DEPTH (CHANNELS)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Clearing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    // Compare stage: change detect against stored level, with write forwarding
    always_comb
    begin
        old_level  = s1_fwd_reg ? s1_fwd_data_reg : mem_rd_data;
        cw         = s1_cand_reg && (old_level != s1_byte_reg);
        has_result = cw || s1_last_reg;
        s1_valid_next = accept || (s1_valid_reg && !s1_done);
        change_seen_next = change_seen_reg;
        if (s1_done)
        begin
            change_seen_next = s1_last_reg ? 1'b0 : (change_seen_reg || cw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            change_seen_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            change_seen_reg <= change_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cand_reg     <= cand;
            s1_addr_reg     <= idx[AW-1:0];
            s1_byte_reg     <= pkt_word.payload_byte;
            s1_last_reg     <= pkt_word.last_byte;
            s1_status_reg   <= status_now;
            s1_fwd_reg      <= mem_wr_en && (mem_wr_addr == idx[AW-1:0]);
            s1_fwd_data_reg <= mem_wr_data;
        end
    end

    // Output register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_word_next  = res_word_reg;
        if (out_free)
        begin
            res_valid_next              = s1_valid_reg && has_result;
            res_word_next.channel_write = cw;
            res_word_next.channel       = cw ? 9'(s1_addr_reg) : 9'd0;
            res_word_next.level         = cw ? s1_byte_reg : 8'd0;
            res_word_next.packet_done   = s1_last_reg;
            res_word_next.status        = s1_last_reg ? s1_status_reg : 3'd0;
            res_word_next.any_changed   = s1_last_reg && (change_seen_reg || cw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_word_reg <= res_word_next;
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

`ifndef SYNTH
    // Every result word carries a channel change or a packet end
    a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_word.channel_write || res_word.packet_done))
        else $error("empty result word");

    // Channel and level are zero when no channel changed
    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_word.channel_write) |->
        (res_word.channel == 9'd0 && res_word.level == 8'd0))
        else $error("channel fields set without a write");

    // A held compare stage keeps its byte and address
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_done) |=>
        (s1_valid_reg && $stable(s1_byte_reg) && $stable(s1_addr_reg)))
        else $error("compare stage lost its byte");

    // Sweep ends only after the last store entry
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_reg) |-> ($past(clr_addr_reg) == LAST_ADDR))
        else $error("clearing sweep ended early");

    // No byte reaches the compare stage during the sweep
    a_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !s1_valid_reg)
        else $error("byte in flight during clearing sweep");
`endif

endmodule
